### rtl/mcpt_pkg.sv
// Shared types and constants of the mouse cursor paint tracker.
// Canvas geometry, cell arithmetic constants, action codes and the
// structs passed between the pipeline modules. No dependencies.
package mcpt_pkg;

    localparam int SCREEN_COLS  = 80;
    localparam int SCREEN_ROWS  = 25;
    localparam int CELL_SCALE   = 72;
    localparam int SWATCH_WIDTH = 4;
    localparam int SWATCH_ROWS  = 2;
    localparam int COLOR_COUNT  = 8;

    localparam int CANVAS_W = SCREEN_COLS * CELL_SCALE;
    localparam int CANVAS_H = SCREEN_ROWS * CELL_SCALE;

    localparam int X_W     = 13;
    localparam int Y_W     = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int COLOR_W = 3;
    localparam int SPEED_W = 4;
    localparam int SUM_W   = 15;

    // Division by CELL_SCALE as a multiply by a rounded-up reciprocal.
    localparam int DIV_SHIFT = 19;
    localparam int DIV_RECIP = (2 ** DIV_SHIFT + CELL_SCALE - 1) / CELL_SCALE;

    localparam logic [X_W-1:0]     CURSOR_X_RESET = X_W'(CANVAS_W / 2);
    localparam logic [Y_W-1:0]     CURSOR_Y_RESET = Y_W'(CANVAS_H / 2);
    localparam logic [COL_W-1:0]   CELL_COL_RESET = COL_W'(CANVAS_W / 2 / CELL_SCALE);
    localparam logic [ROW_W-1:0]   CELL_ROW_RESET =
        ROW_W'(SCREEN_ROWS - 1 - CANVAS_H / 2 / CELL_SCALE);
    localparam logic [COLOR_W-1:0] PEN_RESET      = 3'd4;
    localparam logic [COLOR_W-1:0] ERASE_RESET    = 3'd7;
    localparam logic [SPEED_W-1:0] SPEED_RESET    = 4'd1;

    localparam logic CFG_ERASE_COLOR   = 1'b0;
    localparam logic CFG_POINTER_SPEED = 1'b1;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_PAINT  = 2'd1,
        ACT_ERASE  = 2'd2,
        ACT_SELECT = 2'd3
    } action_t;

    typedef struct packed {
        logic [X_W-1:0] nx;
        logic [Y_W-1:0] ny;
        logic           left;
        logic           right;
    } pipe_t;

    // Lowest field last, so the packed struct matches the stream layout.
    typedef struct packed {
        logic [COLOR_W-1:0] draw_color;
        action_t            action;
        logic [ROW_W-1:0]   new_row;
        logic [COL_W-1:0]   new_col;
        logic [ROW_W-1:0]   old_row;
        logic [COL_W-1:0]   old_col;
    } result_t;

endpackage

### rtl/mcpt_move.sv
// First stage: scale the packet deltas, move and clamp the canvas cursor,
// and register the new position for the cell stage. Uses mcpt_pkg.
module mcpt_move (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      status_flags,
    input  logic [7:0]                      delta_x_low,
    input  logic [7:0]                      delta_y_low,
    input  logic [mcpt_pkg::SPEED_W-1:0]    pointer_speed,
    input  logic                            down_ready,
    output logic                            pipe_valid,
    output mcpt_pkg::pipe_t                 pipe
);
    import mcpt_pkg::*;

    logic [X_W-1:0]          cursor_x_reg, cursor_x_next;
    logic [Y_W-1:0]          cursor_y_reg, cursor_y_next;
    logic                    pipe_valid_reg, pipe_valid_next;
    pipe_t                   pipe_reg;
    logic                    load;
    logic signed [8:0]       dx9, dy9;
    logic signed [SUM_W-1:0] speed_s;
    logic signed [SUM_W-1:0] dx_s, dy_s, sum_x, sum_y;

    assign in_ready = !pipe_valid_reg || down_ready;
    // Drop packets with either overflow bit set.
    assign load = in_valid && in_ready && (status_flags[7:6] == 2'b00);

    always_comb
    begin
        dx9     = {status_flags[4], delta_x_low};
        dy9     = {status_flags[5], delta_y_low};
        speed_s = $signed(SUM_W'(pointer_speed));
        dx_s    = SUM_W'(dx9) * speed_s;
        dy_s    = SUM_W'(dy9) * speed_s;
        sum_x   = $signed(SUM_W'(cursor_x_reg)) + dx_s;
        sum_y   = $signed(SUM_W'(cursor_y_reg)) + dy_s;

        if (sum_x < 0)
            cursor_x_next = '0;
        else if (sum_x >= SUM_W'(CANVAS_W))
            cursor_x_next = X_W'(CANVAS_W - 1);
        else
            cursor_x_next = sum_x[X_W-1:0];

        if (sum_y < 0)
            cursor_y_next = '0;
        else if (sum_y >= SUM_W'(CANVAS_H))
            cursor_y_next = Y_W'(CANVAS_H - 1);
        else
            cursor_y_next = sum_y[Y_W-1:0];

        if (load)
            pipe_valid_next = 1'b1;
        else if (down_ready)
            pipe_valid_next = 1'b0;
        else
            pipe_valid_next = pipe_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= CURSOR_X_RESET;
            cursor_y_reg   <= CURSOR_Y_RESET;
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            pipe_valid_reg <= pipe_valid_next;
            if (load)
            begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pipe_reg.nx    <= cursor_x_next;
            pipe_reg.ny    <= cursor_y_next;
            pipe_reg.left  <= status_flags[0];
            pipe_reg.right <= status_flags[1];
        end
    end

    assign pipe_valid = pipe_valid_reg;
    assign pipe       = pipe_reg;

endmodule

### rtl/mcpt_cell.sv
// Second stage: turn the registered position into a character cell, decide
// the action and keep the pen colour and last cell. Uses mcpt_pkg.
module mcpt_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  mcpt_pkg::pipe_t               pipe,
    input  logic [mcpt_pkg::COLOR_W-1:0]  erase_color,
    output mcpt_pkg::result_t             result
);
    import mcpt_pkg::*;

    logic [COL_W-1:0]   last_col_reg;
    logic [ROW_W-1:0]   last_row_reg;
    logic [COLOR_W-1:0] pen_reg, pen_next;
    logic [31:0]        prod_x, prod_y;
    logic [COL_W-1:0]   nc;
    logic [ROW_W-1:0]   qy, nrow;
    logic               strip;

    always_comb
    begin
        prod_x = 32'(pipe.nx) * 32'(DIV_RECIP);
        prod_y = 32'(pipe.ny) * 32'(DIV_RECIP);
        nc     = prod_x[DIV_SHIFT +: COL_W];
        qy     = prod_y[DIV_SHIFT +: ROW_W];
        nrow   = ROW_W'(SCREEN_ROWS - 1) - qy;
        strip  = (nc < COL_W'(SWATCH_WIDTH * COLOR_COUNT))
              && (nrow >= ROW_W'(SCREEN_ROWS - SWATCH_ROWS));

        pen_next          = pen_reg;
        result.old_col    = last_col_reg;
        result.old_row    = last_row_reg;
        result.new_col    = nc;
        result.new_row    = nrow;
        result.action     = ACT_NONE;
        result.draw_color = '0;

        priority if (pipe.left && strip)
        begin
            pen_next          = COLOR_W'(nc / SWATCH_WIDTH);
            result.action     = ACT_SELECT;
            result.draw_color = pen_next;
        end
        else if (pipe.left)
        begin
            result.action     = ACT_PAINT;
            result.draw_color = pen_reg;
        end
        else if (pipe.right && !strip)
        begin
            result.action     = ACT_ERASE;
            result.draw_color = erase_color;
        end
        else
        begin
            result.action     = ACT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= CELL_COL_RESET;
            last_row_reg <= CELL_ROW_RESET;
            pen_reg      <= PEN_RESET;
        end
        else if (fire)
        begin
            last_col_reg <= nc;
            last_row_reg <= nrow;
            pen_reg      <= pen_next;
        end
    end

endmodule

### rtl/mcpt_outq.sv
// Two-entry result queue that holds finished items until the sink takes
// them, so the pipeline never waits on the sink directly. Uses mcpt_pkg.
module mcpt_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mcpt_pkg::result_t push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output mcpt_pkg::result_t out_data
);
    import mcpt_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    head_reg, tail_reg;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (count_reg == 2'd2)
        begin
            if (pop)
                head_reg <= tail_reg;
        end
        else if (count_reg == 2'd1)
        begin
            if (push && pop)
                head_reg <= push_data;
            else if (push)
                tail_reg <= push_data;
        end
        else if (push)
        begin
            head_reg <= push_data;
        end
    end

endmodule

### rtl/mouse_cursor_paint_tracker_core.sv
// Top level of the mouse cursor paint tracker.
// Instantiates mcpt_move, mcpt_cell and mcpt_outq; uses mcpt_pkg.
//
// Takes one three-byte PS/2 mouse packet per item on the slave stream and
// gives at most one result item on the master stream. A packet with either
// overflow bit set is dropped: no result, cursor and pen unchanged. Otherwise
// each 9-bit signed delta is multiplied by pointer_speed and added to a
// canvas cursor of 5760 by 1800 positions, clamped to the canvas edges. The
// result carries the character cell before and after the move (position
// divided by 72, row counted from the top), an action code and a colour.
// A left click in the palette strip (left 32 columns of the bottom two rows)
// selects pen colour new_col/4; a left click elsewhere paints with the pen,
// a right click outside the strip erases with erase_color; left wins over
// right and the middle button is ignored.
// Rate: one packet per cycle while the result queue has room. Accepted
// packets are registered in the cursor update register, then pass the
// combinational cell division and action stage into a two-entry result
// queue that drives m_tvalid. s_tready falls only when the queue is full
// and the cell stage holds an item.
module mouse_cursor_paint_tracker_core (
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream: [7:0] status_flags, [15:8] delta_x_low, [23:16] delta_y_low
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // Master stream: [6:0] old_col, [11:7] old_row, [18:12] new_col,
    // [23:19] new_row, [25:24] action, [28:26] draw_color, [31:29] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // Configuration: index 0 erase_color, index 1 pointer_speed
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);
    import mcpt_pkg::*;

    logic [COLOR_W-1:0] erase_color_reg;
    logic [SPEED_W-1:0] pointer_speed_reg;
    logic               pipe_valid;
    pipe_t              pipe;
    logic               space;
    logic               fire;
    result_t            cell_result;
    result_t            out_result;

    // Configuration registers; no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_color_reg   <= ERASE_RESET;
            pointer_speed_reg <= SPEED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ERASE_COLOR:   erase_color_reg   <= cfg_data[COLOR_W-1:0];
                CFG_POINTER_SPEED: pointer_speed_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Advance the cell stage when it holds an item and the queue has room.
    assign fire = pipe_valid && space;

    mcpt_move u_move (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .status_flags  (s_tdata[7:0]),
        .delta_x_low   (s_tdata[15:8]),
        .delta_y_low   (s_tdata[23:16]),
        .pointer_speed (pointer_speed_reg),
        .down_ready    (space),
        .pipe_valid    (pipe_valid),
        .pipe          (pipe)
    );

    mcpt_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .pipe        (pipe),
        .erase_color (erase_color_reg),
        .result      (cell_result)
    );

    mcpt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (cell_result),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {3'b000, out_result};

endmodule

### rtl/mcpt_check.sv
// Port-level checker for the mouse cursor paint tracker, bound to the top
// level. Uses mcpt_pkg for canvas limits and action codes.
module mcpt_check (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import mcpt_pkg::*;

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or vanished");

    // Cells stay on screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:0] < 7'(SCREEN_COLS) && m_tdata[11:7] < 5'(SCREEN_ROWS)
                  && m_tdata[18:12] < 7'(SCREEN_COLS) && m_tdata[23:19] < 5'(SCREEN_ROWS))
    else $error("cell outside screen");

    // No action carries no colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[25:24] == ACT_NONE |-> m_tdata[28:26] == 3'd0)
    else $error("colour given without action");

    // Pen selection only inside the strip, with the swatch colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[25:24] == ACT_SELECT
        |-> m_tdata[18:12] < 7'(SWATCH_WIDTH * COLOR_COUNT)
         && m_tdata[23:19] >= 5'(SCREEN_ROWS - SWATCH_ROWS)
         && m_tdata[28:26] == 3'(m_tdata[18:12] / SWATCH_WIDTH))
    else $error("pen selection outside palette strip");

endmodule

bind mouse_cursor_paint_tracker_core mcpt_check u_check (.*);
